[design/sbo_pkg.sv]
// Shared constants and types for the segment/box overlap test pipeline.
// No dependencies; the other design files, bar sbo_result_if, refer to it by scoped name.
package sbo_pkg;

	// Default coordinate width: signed Q16.16 in 32 bits.
	localparam int unsigned COORD_BITS = 32;

	// Load enables for the pipeline stages that live inside the cross-axis units.
	typedef struct packed {
		logic s3;
		logic s4;
		logic s5;
	} stage_en_t;

endpackage

[design/sbo_query_if.sv]
// Request channel of the segment/box overlap test: segment end points and box.
// Depends on sbo_pkg for the default coordinate width.
interface sbo_query_if #(
	parameter int unsigned COORD_BITS = sbo_pkg::COORD_BITS
);
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] start_x;
	logic signed [COORD_BITS-1:0] start_y;
	logic signed [COORD_BITS-1:0] start_z;
	logic signed [COORD_BITS-1:0] end_x;
	logic signed [COORD_BITS-1:0] end_y;
	logic signed [COORD_BITS-1:0] end_z;
	logic signed [COORD_BITS-1:0] center_x;
	logic signed [COORD_BITS-1:0] center_y;
	logic signed [COORD_BITS-1:0] center_z;
	logic        [COORD_BITS-2:0] half_x;
	logic        [COORD_BITS-2:0] half_y;
	logic        [COORD_BITS-2:0] half_z;

	modport source (
		output valid, start_x, start_y, start_z, end_x, end_y, end_z,
		output center_x, center_y, center_z, half_x, half_y, half_z,
		input  ready
	);

	modport sink (
		input  valid, start_x, start_y, start_z, end_x, end_y, end_z,
		input  center_x, center_y, center_z, half_x, half_y, half_z,
		output ready
	);
endinterface

[design/sbo_result_if.sv]
// Result channel of the segment/box overlap test: one overlap flag per request.
// No dependencies.
interface sbo_result_if;
	logic valid;
	logic ready;
	logic hit;

	modport source (
		output valid, hit,
		input  ready
	);

	modport sink (
		input  valid, hit,
		output ready
	);
endinterface

[design/segment_box_overlap_test_core.sv]
// Segment versus axis-aligned box overlap test, separating-axis method, exact arithmetic.
// Throughput: one request per cycle while the output is not stalled;
// the six pipeline stages each hold a valid bit.
// A stalled output only holds the full stages; empty stages upstream keep filling.
// Reset (arst_n low, asynchronous) clears all valid bits; the data path is not reset.
// Depends on sbo_pkg, sbo_query_if, sbo_result_if, sbo_mul and sbo_cross.
module segment_box_overlap_test_core #(
	parameter int unsigned COORD_BITS = sbo_pkg::COORD_BITS
) (
	input  logic         clk,
	input  logic         arst_n,
	sbo_query_if.sink    query,
	sbo_result_if.source result
);
	// Doubled direction D = end - start and doubled offset M = end + start - 2*center
	// are held exactly, so the halving of the textbook test never rounds.
	localparam int unsigned CW = COORD_BITS;
	localparam int unsigned DW = CW + 1;
	localparam int unsigned MW = CW + 2;
	localparam int unsigned HW = CW - 1;

	// Stage valid bits and the ready chain. A stage takes a new request when it is
	// empty or when the stage after it takes its current one.
	logic [6:1] vld;
	logic [6:1] rdy;
	sbo_pkg::stage_en_t stage_en;

	assign rdy[6] = ~vld[6] | result.ready;
	assign rdy[5] = ~vld[5] | rdy[6];
	assign rdy[4] = ~vld[4] | rdy[5];
	assign rdy[3] = ~vld[3] | rdy[4];
	assign rdy[2] = ~vld[2] | rdy[3];
	assign rdy[1] = ~vld[1] | rdy[2];

	assign query.ready  = rdy[1];
	assign stage_en.s3  = rdy[3];
	assign stage_en.s4  = rdy[4];
	assign stage_en.s5  = rdy[5];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld <= '0;
		end else begin
			if (rdy[1]) vld[1] <= query.valid;
			if (rdy[2]) vld[2] <= vld[1];
			if (rdy[3]) vld[3] <= vld[2];
			if (rdy[4]) vld[4] <= vld[3];
			if (rdy[5]) vld[5] <= vld[4];
			if (rdy[6]) vld[6] <= vld[5];
		end
	end

	// Per-axis views of the request so the three axes share one description.
	logic [CW-1:0] pt_s[3];
	logic [CW-1:0] pt_e[3];
	logic [CW-1:0] pt_c[3];
	logic [HW-1:0] hin[3];

	assign pt_s[0] = query.start_x;
	assign pt_s[1] = query.start_y;
	assign pt_s[2] = query.start_z;
	assign pt_e[0] = query.end_x;
	assign pt_e[1] = query.end_y;
	assign pt_e[2] = query.end_z;
	assign pt_c[0] = query.center_x;
	assign pt_c[1] = query.center_y;
	assign pt_c[2] = query.center_z;
	assign hin[0]  = query.half_x;
	assign hin[1]  = query.half_y;
	assign hin[2]  = query.half_z;

	// Stage 1: D and M in two's complement, wide enough that nothing wraps.
	// Stage 2: split D and M into magnitude and sign.
	// Stage 3: box-axis compares |M| > 2h + |D|, and the cross-axis partial products.
	logic [DW-1:0] d_s1[3];
	logic [MW-1:0] m_s1[3];
	logic [HW-1:0] h_s1[3];
	logic [DW-1:0] dmag_s2[3];
	logic [MW-1:0] mmag_s2[3];
	logic          dneg_s2[3];
	logic          mneg_s2[3];
	logic [HW-1:0] h_s2[3];
	logic [2:0]    box_sep;
	logic          box_sep_s3;
	logic          box_sep_s4;
	logic          box_sep_s5;
	logic [2:0]    cross_sep;
	logic          hit_s6;

	always_ff @(posedge clk) begin
		if (rdy[1]) begin
			for (int i = 0; i < 3; i++) begin
				d_s1[i] <= {pt_e[i][CW-1], pt_e[i]} - {pt_s[i][CW-1], pt_s[i]};
				m_s1[i] <= {{2{pt_e[i][CW-1]}}, pt_e[i]}
					+ {{2{pt_s[i][CW-1]}}, pt_s[i]}
					- {pt_c[i][CW-1], pt_c[i], 1'b0};
				h_s1[i] <= hin[i];
			end
		end
		if (rdy[2]) begin
			for (int i = 0; i < 3; i++) begin
				dneg_s2[i] <= d_s1[i][DW-1];
				mneg_s2[i] <= m_s1[i][MW-1];
				dmag_s2[i] <= d_s1[i][DW-1] ? (DW'(0) - d_s1[i]) : d_s1[i];
				mmag_s2[i] <= m_s1[i][MW-1] ? (MW'(0) - m_s1[i]) : m_s1[i];
				h_s2[i]    <= h_s1[i];
			end
		end
		if (rdy[3]) box_sep_s3 <= |box_sep;
		if (rdy[4]) box_sep_s4 <= box_sep_s3;
		if (rdy[5]) box_sep_s5 <= box_sep_s4;
		// Stage 6 is the output register: overlap unless some axis separates.
		if (rdy[6]) hit_s6 <= ~(box_sep_s5 | (|cross_sep));
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			box_sep[i] = mmag_s2[i] > (MW'({h_s2[i], 1'b0}) + MW'(dmag_s2[i]));
		end
	end

	// Cross axes pair (y,z), (z,x) and (x,y). A degenerate segment has all D zero,
	// so every cross term is zero and only the box axes can separate.
	sbo_cross #(.COORD_BITS(CW)) u_cross_x (
		.clk(clk), .stage_en(stage_en),
		.dj(dmag_s2[1]), .dk(dmag_s2[2]), .dj_neg(dneg_s2[1]), .dk_neg(dneg_s2[2]),
		.mj(mmag_s2[1]), .mk(mmag_s2[2]), .mj_neg(mneg_s2[1]), .mk_neg(mneg_s2[2]),
		.hj(h_s2[1]), .hk(h_s2[2]), .sep(cross_sep[0])
	);
	sbo_cross #(.COORD_BITS(CW)) u_cross_y (
		.clk(clk), .stage_en(stage_en),
		.dj(dmag_s2[2]), .dk(dmag_s2[0]), .dj_neg(dneg_s2[2]), .dk_neg(dneg_s2[0]),
		.mj(mmag_s2[2]), .mk(mmag_s2[0]), .mj_neg(mneg_s2[2]), .mk_neg(mneg_s2[0]),
		.hj(h_s2[2]), .hk(h_s2[0]), .sep(cross_sep[1])
	);
	sbo_cross #(.COORD_BITS(CW)) u_cross_z (
		.clk(clk), .stage_en(stage_en),
		.dj(dmag_s2[0]), .dk(dmag_s2[1]), .dj_neg(dneg_s2[0]), .dk_neg(dneg_s2[1]),
		.mj(mmag_s2[0]), .mk(mmag_s2[1]), .mj_neg(mneg_s2[0]), .mk_neg(mneg_s2[1]),
		.hj(h_s2[0]), .hk(h_s2[1]), .sep(cross_sep[2])
	);

	assign result.valid = vld[6];
	assign result.hit   = hit_s6;
endmodule

[design/sbo_mul.sv]
// Two-stage unsigned multiplier: four registered half-width partial products,
// then a registered sum. Depends on sbo_pkg for the stage enable type.
module sbo_mul #(
	parameter int unsigned AW = 33,
	parameter int unsigned BW = 34
) (
	input  logic              clk,
	input  sbo_pkg::stage_en_t stage_en,
	input  logic [AW-1:0]     a,
	input  logic [BW-1:0]     b,
	output logic [AW+BW-1:0]  p
);
	localparam int unsigned AL = (AW + 1) / 2;
	localparam int unsigned AH = AW - AL;
	localparam int unsigned BL = (BW + 1) / 2;
	localparam int unsigned BH = BW - BL;
	localparam int unsigned PW = AW + BW;

	logic [AL+BL-1:0] pp_ll_s3;
	logic [AL+BH-1:0] pp_lh_s3;
	logic [AH+BL-1:0] pp_hl_s3;
	logic [AH+BH-1:0] pp_hh_s3;
	logic [PW-1:0]    p_s4;

	always_ff @(posedge clk) begin
		if (stage_en.s3) begin
			pp_ll_s3 <= a[AL-1:0]  * b[BL-1:0];
			pp_lh_s3 <= a[AL-1:0]  * b[BW-1:BL];
			pp_hl_s3 <= a[AW-1:AL] * b[BL-1:0];
			pp_hh_s3 <= a[AW-1:AL] * b[BW-1:BL];
		end
		if (stage_en.s4) begin
			p_s4 <= PW'(pp_ll_s3)
				+ (PW'(pp_lh_s3) << BL)
				+ (PW'(pp_hl_s3) << AL)
				+ (PW'(pp_hh_s3) << (AL + BL));
		end
	end

	assign p = p_s4;
endmodule

[design/sbo_cross.sv]
// One cross-product axis of the separating-axis test (box axis x segment direction).
// Depends on sbo_pkg and sbo_mul; spans pipeline stages three to five.
module sbo_cross #(
	parameter int unsigned COORD_BITS = sbo_pkg::COORD_BITS
) (
	input  logic                   clk,
	input  sbo_pkg::stage_en_t     stage_en,
	input  logic [COORD_BITS:0]    dj,
	input  logic [COORD_BITS:0]    dk,
	input  logic                   dj_neg,
	input  logic                   dk_neg,
	input  logic [COORD_BITS+1:0]  mj,
	input  logic [COORD_BITS+1:0]  mk,
	input  logic                   mj_neg,
	input  logic                   mk_neg,
	input  logic [COORD_BITS-2:0]  hj,
	input  logic [COORD_BITS-2:0]  hk,
	output logic                   sep
);
	localparam int unsigned DW = COORD_BITS + 1;
	localparam int unsigned MW = COORD_BITS + 2;
	localparam int unsigned HW = COORD_BITS - 1;
	localparam int unsigned PW = DW + MW;
	localparam int unsigned QW = HW + DW;
	localparam int unsigned FW = 2 * COORD_BITS + 4;
	localparam int unsigned RW = 2 * COORD_BITS + 2;

	logic [PW-1:0] pa;
	logic [PW-1:0] pb;
	logic [QW-1:0] qc;
	logic [QW-1:0] qe;
	logic          neg_a_s3, neg_a_s4;
	logic          neg_b_s3, neg_b_s4;
	logic [FW-1:0] term_a;
	logic [FW-1:0] term_b;
	logic [FW-1:0] f_s5;
	logic [RW-1:0] r_s5;
	logic signed [FW-1:0] f_sg;
	logic signed [FW-1:0] r_sg;

	// Dj*Mk and Dk*Mj on magnitudes; signs are applied after the sum stage.
	sbo_mul #(.AW(DW), .BW(MW)) u_mul_a (
		.clk(clk), .stage_en(stage_en), .a(dj), .b(mk), .p(pa)
	);
	sbo_mul #(.AW(DW), .BW(MW)) u_mul_b (
		.clk(clk), .stage_en(stage_en), .a(dk), .b(mj), .p(pb)
	);
	// Projected box radius terms hj*|Dk| and hk*|Dj|.
	sbo_mul #(.AW(HW), .BW(DW)) u_mul_c (
		.clk(clk), .stage_en(stage_en), .a(hj), .b(dk), .p(qc)
	);
	sbo_mul #(.AW(HW), .BW(DW)) u_mul_e (
		.clk(clk), .stage_en(stage_en), .a(hk), .b(dj), .p(qe)
	);

	assign term_a = neg_a_s4 ? (FW'(0) - FW'(pa)) : FW'(pa);
	assign term_b = neg_b_s4 ? (FW'(0) - FW'(pb)) : FW'(pb);

	always_ff @(posedge clk) begin
		if (stage_en.s3) begin
			neg_a_s3 <= dj_neg ^ mk_neg;
			neg_b_s3 <= dk_neg ^ mj_neg;
		end
		if (stage_en.s4) begin
			neg_a_s4 <= neg_a_s3;
			neg_b_s4 <= neg_b_s3;
		end
		if (stage_en.s5) begin
			f_s5 <= term_a - term_b;
			r_s5 <= {RW'(qc) + RW'(qe)} << 1;
		end
	end

	// |f| > r is split into f > r or f < -r, two compares in parallel.
	assign f_sg = $signed(f_s5);
	assign r_sg = $signed(FW'(r_s5));
	assign sep  = (f_sg > r_sg) || (f_sg < -r_sg);
endmodule
